// ----- sv/timed_event_queue_defines.svh -----
// assertion helpers for the timed event queue rtl
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TEQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/teq_pkg.sv -----
`default_nettype none
package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_W          = 32;
    localparam int PROC_W          = 8;
    localparam int OP_W            = 4;
    localparam int KIND_W          = 4;
    localparam int COUNT_OUT_W     = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POLL   = 1'b1
    } action_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic [PROC_W-1:0] process_number;
        logic [OP_W-1:0]   operation_code;
        logic [KIND_W-1:0] interrupt_kind;
    } entry_t;

    typedef struct packed {
        action_t           action;
        logic [TIME_W-1:0] time_value;
        logic [PROC_W-1:0] process_number;
        logic [OP_W-1:0]   operation_code;
        logic [KIND_W-1:0] interrupt_kind;
    } req_t;

    typedef struct packed {
        logic                   event_valid;
        logic [TIME_W-1:0]      out_time;
        logic [PROC_W-1:0]      out_process;
        logic [OP_W-1:0]        out_operation;
        logic [KIND_W-1:0]      out_kind;
        logic                   queue_full;
        logic [COUNT_OUT_W-1:0] queue_count;
    } rsp_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert_en;
        logic pop_en;
    } ctrl_t;

endpackage
`default_nettype wire

// ----- sv/teq_stream_if.sv -----
`default_nettype none
interface teq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/teq_cell.sv -----
`default_nettype none
module teq_cell (
    input  wire logic            clk,
    input  wire teq_pkg::ctrl_t  ctrl,
    input  wire teq_pkg::entry_t new_entry,
    input  wire logic            occupied,
    input  wire logic            left_lt,
    input  wire teq_pkg::entry_t left_entry,
    input  wire teq_pkg::entry_t right_entry,
    output teq_pkg::entry_t      entry,
    output logic                 lt
);

    teq_pkg::entry_t entry_reg;
    teq_pkg::entry_t entry_next;

    // stored event is strictly earlier than the incoming one
    assign lt    = occupied && (entry_reg.time_value < new_entry.time_value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.insert_en)
        begin
            // earlier entries stay, the insert slot takes the new beat, equal or later ones shift right
            if (!lt)
            begin
                entry_next = left_lt ? new_entry : left_entry;
            end
        end
        else if (ctrl.pop_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ----- sv/teq_chain.sv -----
`default_nettype none
module teq_chain #(
    parameter  int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire teq_pkg::ctrl_t   ctrl,
    input  wire teq_pkg::entry_t  new_entry,
    input  wire logic [CNT_W-1:0] count,
    output teq_pkg::entry_t       head
);

    teq_pkg::entry_t cell_entry [QUEUE_DEPTH];
    logic            cell_lt    [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic            occupied;
        logic            left_lt;
        teq_pkg::entry_t left_entry;
        teq_pkg::entry_t right_entry;

        assign occupied = count > CNT_W'(i);

        if (i == 0)
        begin : g_first
            // head acts as if a smaller sentinel sat to its left
            assign left_lt    = 1'b1;
            assign left_entry = new_entry;
        end
        else
        begin : g_inner
            assign left_lt    = cell_lt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = new_entry;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        teq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .occupied    (occupied),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .lt          (cell_lt[i])
        );
    end

    assign head = cell_entry[0];

endmodule
`default_nettype wire

// ----- sv/timed_event_queue.sv -----
// Timed event queue: a sorted row of QUEUE_DEPTH cells holding pending events,
// earliest due time at the head. An insert beat (action 0) places the event ahead
// of every stored event with an equal or later time; a poll beat (action 1) removes
// and returns the head if its time is at or before the carried time. Every request
// beat yields exactly one response beat, registered, in the cycle after acceptance.
// One request is taken every clock cycle: each cell compares its stored time with
// the incoming time in parallel and moves one slot left or right in the same cycle,
// so a beat's cost is a single 32-bit compare per cell plus the head compare. The
// request side stalls only while a response waits unread. Inserts into a full queue
// are dropped and flagged with queue_full; queue_count reports stored events after
// the beat (low 5 bits).
`default_nettype none
`include "timed_event_queue_defines.svh"
module timed_event_queue #(
    parameter  int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    teq_stream_if.sink  req,
    teq_stream_if.source rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    teq_pkg::rsp_t    rsp_reg;
    teq_pkg::rsp_t    rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    teq_pkg::ctrl_t   ctrl;
    teq_pkg::entry_t  new_entry;
    teq_pkg::entry_t  head;
    logic             accept;
    logic             full;
    logic             due;
    logic             is_insert;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_insert = req.data.action == teq_pkg::ACT_INSERT;

    assign new_entry.time_value     = req.data.time_value;
    assign new_entry.process_number = req.data.process_number;
    assign new_entry.operation_code = req.data.operation_code;
    assign new_entry.interrupt_kind = req.data.interrupt_kind;

    assign full = count_reg == CNT_W'(QUEUE_DEPTH);
    assign due  = (count_reg != '0) && (head.time_value <= req.data.time_value);

    assign ctrl.insert_en = accept && is_insert && !full;
    assign ctrl.pop_en    = accept && !is_insert && due;

    teq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .count     (count_reg),
        .head      (head)
    );

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.insert_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.queue_count = teq_pkg::COUNT_OUT_W'(count_next);
        rsp_next.queue_full  = is_insert && full;
        if (ctrl.pop_en)
        begin
            rsp_next.event_valid   = 1'b1;
            rsp_next.out_time      = head.time_value;
            rsp_next.out_process   = head.process_number;
            rsp_next.out_operation = head.operation_code;
            rsp_next.out_kind      = head.interrupt_kind;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload only moves on an accepted request beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    `TEQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `TEQ_ASSERT_IMP(a_pop_nonempty, ctrl.pop_en, count_reg != '0, "pop from empty queue")
    `TEQ_ASSERT_NXT(a_insert_grows, ctrl.insert_en, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `TEQ_ASSERT_IMP(a_event_not_full, rsp_valid_reg && rsp_reg.event_valid, !rsp_reg.queue_full, "event beat flagged full")

endmodule
`default_nettype wire

// ----- tb/sv/timed_event_queue_tb.sv -----
`default_nettype none
module timed_event_queue_tb;

    localparam int EVENT_SLOTS  = teq_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 215;
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_TICKS = 20;
    localparam logic [teq_pkg::TIME_W-1:0] TIME_MAX = '1;
    localparam logic [teq_pkg::TIME_W-1:0] ONE_SEC  = 32'h0010_0000;

    typedef struct {
        teq_pkg::req_t beat;
        bit            wait_drain;
        bit            no_gap;
    } send_slot_t;

    logic clk = 1'b0;
    logic rst_n;

    teq_stream_if #(.payload_t(teq_pkg::req_t)) req_if ();
    teq_stream_if #(.payload_t(teq_pkg::rsp_t)) rsp_if ();

    timed_event_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // sorted copy of the event list, earliest due time first
    teq_pkg::entry_t held_events [EVENT_SLOTS];
    int              held_count = 0;

    send_slot_t    send_queue [$];
    teq_pkg::rsp_t queued_outcomes [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            steady = 1'b0;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic teq_pkg::rsp_t update_event_list(teq_pkg::req_t beat);
        teq_pkg::rsp_t outcome;
        int            pos;
        outcome = '0;
        if (beat.action == teq_pkg::ACT_INSERT) begin
            if (held_count >= EVENT_SLOTS) begin
                outcome.queue_full = 1'b1;
            end
            else begin
                pos = 0;
                while (pos < held_count && held_events[pos].time_value < beat.time_value)
                    pos++;
                for (int i = held_count; i > pos; i--)
                    held_events[i] = held_events[i-1];
                held_events[pos].time_value     = beat.time_value;
                held_events[pos].process_number = beat.process_number;
                held_events[pos].operation_code = beat.operation_code;
                held_events[pos].interrupt_kind = beat.interrupt_kind;
                held_count++;
            end
        end
        else if (held_count > 0 && held_events[0].time_value <= beat.time_value) begin
            outcome.event_valid   = 1'b1;
            outcome.out_time      = held_events[0].time_value;
            outcome.out_process   = held_events[0].process_number;
            outcome.out_operation = held_events[0].operation_code;
            outcome.out_kind      = held_events[0].interrupt_kind;
            for (int i = 1; i < held_count; i++)
                held_events[i-1] = held_events[i];
            held_count--;
        end
        outcome.queue_count = teq_pkg::COUNT_OUT_W'(held_count);
        return outcome;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic add_beat(input teq_pkg::action_t act,
                            input logic [teq_pkg::TIME_W-1:0] t,
                            input logic [teq_pkg::PROC_W-1:0] p,
                            input logic [teq_pkg::OP_W-1:0] op,
                            input logic [teq_pkg::KIND_W-1:0] k, input bit wait_drain,
                            input bit no_gap);
        send_slot_t slot;
        slot.beat.action         = act;
        slot.beat.time_value     = t;
        slot.beat.process_number = p;
        slot.beat.operation_code = op;
        slot.beat.interrupt_kind = k;
        slot.wait_drain          = wait_drain;
        slot.no_gap              = no_gap;
        send_queue.push_back(slot);
    endtask

    // request driver
    always @(posedge clk) begin : drive_beats
        send_slot_t    slot;
        logic          nv;
        teq_pkg::req_t nd;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end
        else begin
            nv = req_if.valid;
            nd = req_if.data;
            if (req_if.valid && req_if.ready) begin
                queued_outcomes.push_back(update_event_list(req_if.data));
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (send_queue.size() > 0 &&
                         !(send_queue[0].wait_drain && queued_outcomes.size() > 0)) begin
                    slot     = send_queue.pop_front();
                    nv       = 1'b1;
                    nd       = slot.beat;
                    steady   <= slot.no_gap;
                    gap_left = slot.no_gap ? 0 : pick_gap();
                end
            end
            req_if.valid <= nv;
            req_if.data  <= nd;
        end
    end

    // response monitor
    always @(posedge clk) begin : watch_rsps
        teq_pkg::rsp_t want;
        teq_pkg::rsp_t got;
        logic          nr;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end
        else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (queued_outcomes.size() == 0) begin
                    note_mismatch("response beat with none pending", got.out_time, '0);
                end
                else begin
                    want = queued_outcomes.pop_front();
                    if (got.event_valid !== want.event_valid)
                        note_mismatch("event_valid", 32'(got.event_valid),
                                      32'(want.event_valid));
                    if (got.out_time !== want.out_time)
                        note_mismatch("out_time", got.out_time, want.out_time);
                    if (got.out_process !== want.out_process)
                        note_mismatch("out_process", 32'(got.out_process),
                                      32'(want.out_process));
                    if (got.out_operation !== want.out_operation)
                        note_mismatch("out_operation", 32'(got.out_operation),
                                      32'(want.out_operation));
                    if (got.out_kind !== want.out_kind)
                        note_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
                    if (got.queue_full !== want.queue_full)
                        note_mismatch("queue_full", 32'(got.queue_full),
                                      32'(want.queue_full));
                    if (got.queue_count !== want.queue_count)
                        note_mismatch("queue_count", 32'(got.queue_count),
                                      32'(want.queue_count));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end
            else begin
                nr = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
            rsp_if.ready <= nr;
        end
    end

    initial begin : watchdog
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [teq_pkg::TIME_W-1:0] clock_now;
        logic [teq_pkg::TIME_W-1:0] last_due;
        logic [teq_pkg::TIME_W-1:0] t;
        int                         insert_pct;
        int                         roll;
        bit                         calm;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;

        // empty list polls at both ends of time
        add_beat(teq_pkg::ACT_POLL, '0, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, TIME_MAX, '1, '1, '1, 1'b0, 1'b0);
        // fill to capacity: extremes, a tie on one second, then random times
        add_beat(teq_pkg::ACT_INSERT, TIME_MAX, '1, '1, '1, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_INSERT, '0, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_INSERT, ONE_SEC, 8'h02, 4'h2, 4'h2, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_INSERT, ONE_SEC, 8'h03, 4'h3, 4'h3, 1'b0, 1'b0);
        for (int i = 4; i < EVENT_SLOTS; i++)
            add_beat(teq_pkg::ACT_INSERT, ONE_SEC + $urandom_range(1, 32'h0FFF_FFFF),
                     teq_pkg::PROC_W'($urandom), teq_pkg::OP_W'($urandom),
                     teq_pkg::KIND_W'($urandom), 1'b0, 1'b0);
        // dropped insert on a full list
        add_beat(teq_pkg::ACT_INSERT, 32'h5, 8'hA5, 4'h5, 4'hA, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, '0, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, '0, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, ONE_SEC - 1, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, ONE_SEC, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, ONE_SEC, '0, '0, '0, 1'b0, 1'b0);
        add_beat(teq_pkg::ACT_POLL, TIME_MAX, '0, '0, '0, 1'b0, 1'b0);

        // random phases with a drifting current time; insert share swings so the
        // list runs both empty and full
        clock_now = $urandom_range(0, 32'h00FF_FFFF);
        last_due  = clock_now;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: insert_pct = 50;
                1: insert_pct = 80;
                2: insert_pct = 30;
                3: insert_pct = 60;
                4: insert_pct = 85;
                default: insert_pct = 20;
            endcase
            calm = (ph == 1) || (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < insert_pct) begin
                    case (roll)
                        0: t = $urandom;
                        1, 2: t = last_due;
                        3: t = clock_now;
                        4: t = TIME_MAX - $urandom_range(0, 3);
                        default: t = clock_now + $urandom_range(0, 32'h0040_0000);
                    endcase
                    last_due = t;
                    add_beat(teq_pkg::ACT_INSERT, t, teq_pkg::PROC_W'($urandom),
                             teq_pkg::OP_W'($urandom), teq_pkg::KIND_W'($urandom),
                             n == 0, calm);
                end
                else begin
                    case (roll)
                        0: t = $urandom;
                        1: t = '0;
                        2: t = TIME_MAX;
                        3: t = last_due;
                        default: t = clock_now;
                    endcase
                    // content fields of a poll are don't-care but still toggled
                    add_beat(teq_pkg::ACT_POLL, t, teq_pkg::PROC_W'($urandom),
                             teq_pkg::OP_W'($urandom), teq_pkg::KIND_W'($urandom),
                             n == 0, calm);
                end
                clock_now = clock_now + $urandom_range(0, 32'h0010_0000);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (send_queue.size() == 0);
        @(posedge clk);
        wait (!req_if.valid && queued_outcomes.size() == 0);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0 && queued_outcomes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
